// ===== sv/cc3d_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the sequencer program for the circumcenter block
package cc3d_pkg;

    localparam int MAX_POINTS = 4;
    localparam int COORD_IN_W = 16;
    localparam int OUT_W      = 48;
    localparam int RAM_DEPTH  = 32;
    localparam int ADDR_W     = 5;
    localparam int PROG_LEN   = 64;
    localparam int PC_W       = 6;

    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // scratch memory map
    localparam int A_P0 = 0;
    localparam int A_U  = 3;
    localparam int A_V  = 6;
    localparam int A_W  = 9;
    localparam int A_S1 = 12;
    localparam int A_S2 = 13;
    localparam int A_S3 = 14;
    localparam int A_A  = 15;
    localparam int A_B  = 18;
    localparam int A_C  = 21;
    localparam int A_D  = 24;
    localparam int A_N  = 25;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_TOO_MANY = 2'd1,
        STAT_DEGEN    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_ONE   = 2'd0,
        MODE_TWO   = 2'd1,
        MODE_THREE = 2'd2,
        MODE_FOUR  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_Y,
        ST_WR_Z,
        ST_FETCH,
        ST_MAC_START,
        ST_MAC_RUN,
        ST_WB,
        ST_DIV_FETCH,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        SRC_RAM = 2'd0,
        SRC_ONE = 2'd1,
        SRC_TWO = 2'd2
    } opsrc_t;

    typedef struct packed {
        opsrc_t              src;
        logic [ADDR_W-1:0]   addr;
    } opnd_t;

    typedef struct packed {
        logic                stop;
        logic                clr;
        logic                neg;
        logic                wr;
        opnd_t               x;
        opnd_t               y;
        logic [ADDR_W-1:0]   wa;
    } uop_t;

    typedef struct packed {
        logic start;
        logic clr;
        logic neg;
    } mac_cmd_t;

    localparam opnd_t OP_ONE = '{src: SRC_ONE, addr: '0};
    localparam opnd_t OP_TWO = '{src: SRC_TWO, addr: '0};
    localparam uop_t UOP_STOP = '{stop: 1'b1, clr: 1'b0, neg: 1'b0, wr: 1'b0,
                                  x: OP_ONE, y: OP_ONE, wa: '0};

    function automatic opnd_t rm(input int a);
        opnd_t o;
        o.src  = SRC_RAM;
        o.addr = a[ADDR_W-1:0];
        return o;
    endfunction

    function automatic uop_t t(input opnd_t x, input opnd_t y, input logic clr,
                               input logic neg, input logic wr, input int wa);
        uop_t u;
        u.stop = 1'b0;
        u.clr  = clr;
        u.neg  = neg;
        u.wr   = wr;
        u.x    = x;
        u.y    = y;
        u.wa   = wa[ADDR_W-1:0];
        return u;
    endfunction

    // each entry is one term acc (+/-)= x*y; wr stores acc after the term
    function automatic uop_t prog_at(input mode_t mode, input logic [PC_W-1:0] pc);
        uop_t p [PROG_LEN];
        int   n;
        int   k;
        int   i1;
        int   i2;
        for (k = 0; k < PROG_LEN; k++) begin
            p[k] = UOP_STOP;
        end
        n = 0;
        case (mode)
            MODE_ONE: begin
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_P0 + k), OP_ONE, 1'b1, 1'b0, 1'b1, A_N + k); n++;
                end
                p[n] = t(OP_ONE, OP_ONE, 1'b1, 1'b0, 1'b1, A_D); n++;
            end
            MODE_TWO: begin
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_P0 + k), OP_ONE, 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_U + k), OP_ONE, 1'b0, 1'b0, 1'b1, A_N + k); n++;
                end
                p[n] = t(OP_ONE, OP_TWO, 1'b1, 1'b0, 1'b1, A_D); n++;
            end
            MODE_THREE: begin
                // edges from the first point
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_U + k), OP_ONE, 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_P0 + k), OP_ONE, 1'b0, 1'b1, 1'b1, A_U + k); n++;
                    p[n] = t(rm(A_V + k), OP_ONE, 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_P0 + k), OP_ONE, 1'b0, 1'b1, 1'b1, A_V + k); n++;
                end
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_U + k), rm(A_U + k), k == 0, 1'b0, k == 2, A_S1); n++;
                end
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_V + k), rm(A_V + k), k == 0, 1'b0, k == 2, A_S2); n++;
                end
                // normal n = u x v
                for (k = 0; k < 3; k++) begin
                    i1 = (k == 2) ? 0 : k + 1;
                    i2 = (k == 0) ? 2 : k - 1;
                    p[n] = t(rm(A_U + i1), rm(A_V + i2), 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_U + i2), rm(A_V + i1), 1'b0, 1'b1, 1'b1, A_C + k); n++;
                end
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_C + k), rm(A_C + k), k == 0, 1'b0, k == 2, A_D); n++;
                end
                p[n] = t(rm(A_D), OP_TWO, 1'b1, 1'b0, 1'b1, A_D); n++;
                // g = |v|^2 u - |u|^2 v
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_S2), rm(A_U + k), 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_S1), rm(A_V + k), 1'b0, 1'b1, 1'b1, A_A + k); n++;
                end
                // numerator p0*den + n x g
                for (k = 0; k < 3; k++) begin
                    i1 = (k == 2) ? 0 : k + 1;
                    i2 = (k == 0) ? 2 : k - 1;
                    p[n] = t(rm(A_D), rm(A_P0 + k), 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_C + i1), rm(A_A + i2), 1'b0, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_C + i2), rm(A_A + i1), 1'b0, 1'b1, 1'b1, A_N + k); n++;
                end
            end
            default: begin
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_U + k), OP_ONE, 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_P0 + k), OP_ONE, 1'b0, 1'b1, 1'b1, A_U + k); n++;
                    p[n] = t(rm(A_V + k), OP_ONE, 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_P0 + k), OP_ONE, 1'b0, 1'b1, 1'b1, A_V + k); n++;
                    p[n] = t(rm(A_W + k), OP_ONE, 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_P0 + k), OP_ONE, 1'b0, 1'b1, 1'b1, A_W + k); n++;
                end
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_U + k), rm(A_U + k), k == 0, 1'b0, k == 2, A_S1); n++;
                end
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_V + k), rm(A_V + k), k == 0, 1'b0, k == 2, A_S2); n++;
                end
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_W + k), rm(A_W + k), k == 0, 1'b0, k == 2, A_S3); n++;
                end
                // adjugate columns v x w, w x u, u x v
                for (k = 0; k < 3; k++) begin
                    i1 = (k == 2) ? 0 : k + 1;
                    i2 = (k == 0) ? 2 : k - 1;
                    p[n] = t(rm(A_V + i1), rm(A_W + i2), 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_V + i2), rm(A_W + i1), 1'b0, 1'b1, 1'b1, A_A + k); n++;
                    p[n] = t(rm(A_W + i1), rm(A_U + i2), 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_W + i2), rm(A_U + i1), 1'b0, 1'b1, 1'b1, A_B + k); n++;
                    p[n] = t(rm(A_U + i1), rm(A_V + i2), 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_U + i2), rm(A_V + i1), 1'b0, 1'b1, 1'b1, A_C + k); n++;
                end
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_A + k), rm(A_U + k), k == 0, 1'b0, k == 2, A_D); n++;
                end
                p[n] = t(rm(A_D), OP_TWO, 1'b1, 1'b0, 1'b1, A_D); n++;
                for (k = 0; k < 3; k++) begin
                    p[n] = t(rm(A_D), rm(A_P0 + k), 1'b1, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_S1), rm(A_A + k), 1'b0, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_S2), rm(A_B + k), 1'b0, 1'b0, 1'b0, 0); n++;
                    p[n] = t(rm(A_S3), rm(A_C + k), 1'b0, 1'b0, 1'b1, A_N + k); n++;
                end
            end
        endcase
        return p[pc];
    endfunction

endpackage

// ===== sv/cc3d_ram.sv =====
`timescale 1ns / 1ps
// generic scratch ram, one write port, two registered read ports
module cc3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wa,
    input  logic [WIDTH-1:0]         wd,
    input  logic [$clog2(DEPTH)-1:0] ra_a,
    input  logic [$clog2(DEPTH)-1:0] ra_b,
    output logic [WIDTH-1:0]         rd_a,
    output logic [WIDTH-1:0]         rd_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wa] <= wd;
        end
        rd_a <= mem_reg[ra_a];
        rd_b <= mem_reg[ra_b];
    end

endmodule

// ===== sv/cc3d_mac.sv =====
`timescale 1ns / 1ps
// shift-add multiply-accumulate unit, one multiplier bit per cycle
module cc3d_mac #(
    parameter int W = 88
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cc3d_pkg::mac_cmd_t   cmd,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    output logic                 done,
    output logic signed [W-1:0]  acc
);

    logic                run_reg;
    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] y_reg;
    logic signed [W-1:0] acc_reg;
    logic                y_zero;
    logic                y_ones;

    assign y_zero = (y_reg == '0);
    assign y_ones = (y_reg == '1);
    assign done   = run_reg && (y_zero || y_ones);
    assign acc    = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else if (cmd.start) begin
            run_reg <= 1'b1;
        end else if (done) begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg <= cmd.neg ? -x_in : x_in;
            y_reg <= y_in;
            if (cmd.clr) begin
                acc_reg <= '0;
            end
        end else if (run_reg) begin
            if (y_ones) begin
                // remaining multiplier is -1
                acc_reg <= acc_reg - x_reg;
            end else if (!y_zero) begin
                if (y_reg[0]) begin
                    acc_reg <= acc_reg + x_reg;
                end
                x_reg <= x_reg <<< 1;
                y_reg <= y_reg >>> 1;
            end
        end
    end

endmodule

// ===== sv/cc3d_div.sv =====
`timescale 1ns / 1ps
// restoring divider, rounds to nearest and saturates to the output range
module cc3d_div #(
    parameter int RW        = 88,
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [RW-1:0]               num,
    input  logic signed [RW-1:0]               den,
    output logic                               done,
    output logic [cc3d_pkg::OUT_W-1:0]         quot
);

    localparam int NW = RW + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW:0] HALF = (NW + 1)'(1) << (cc3d_pkg::OUT_W - 1);

    logic                        busy_reg;
    logic                        rnd_reg;
    logic                        done_reg;
    logic [CW-1:0]               cnt_reg;
    logic [NW-1:0]               dvd_reg;
    logic [RW-1:0]               rem_reg;
    logic [RW-1:0]               den_reg;
    logic                        neg_reg;
    logic [NW:0]                 qr_reg;
    logic [cc3d_pkg::OUT_W-1:0]  res_reg;

    logic [RW-1:0] num_abs;
    logic [RW-1:0] den_abs;
    logic [RW-1:0] rem_sh;
    logic          fits;
    logic [RW:0]   rem_dbl;
    logic [NW:0]   qr_neg;

    assign num_abs = num[RW-1] ? RW'(-num) : RW'(num);
    assign den_abs = den[RW-1] ? RW'(-den) : RW'(den);
    assign rem_sh  = {rem_reg[RW-2:0], dvd_reg[NW-1]};
    assign fits    = (rem_sh >= den_reg);
    assign rem_dbl = {rem_reg, 1'b0};
    assign qr_neg  = ~qr_reg + (NW + 1)'(1);
    assign done    = done_reg;
    assign quot    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= rnd_reg;
            rnd_reg  <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= NW'(num_abs) << FRAC_BITS;
            den_reg <= den_abs;
            rem_reg <= '0;
            cnt_reg <= CW'(NW);
            neg_reg <= num[RW-1] ^ den[RW-1];
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_reg <= fits ? rem_sh - den_reg : rem_sh;
                dvd_reg <= {dvd_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
            end else begin
                // ties away from zero
                qr_reg <= {1'b0, dvd_reg} + (NW + 1)'(rem_dbl >= {1'b0, den_reg});
            end
        end
        if (rnd_reg) begin
            if (!neg_reg) begin
                res_reg <= (qr_reg >= HALF) ? cc3d_pkg::SAT_MAX
                                            : qr_reg[cc3d_pkg::OUT_W-1:0];
            end else begin
                res_reg <= (qr_reg > HALF) ? cc3d_pkg::SAT_MIN
                                           : qr_neg[cc3d_pkg::OUT_W-1:0];
            end
        end
    end

endmodule

// ===== sv/circumcenter_3d_fixed.sv =====
`timescale 1ns / 1ps
// circumcenter of one to four 3d points: loader, sequencer, shared mac and divider
// each point is written one coordinate per cycle (one scratch write port)
// closing point: up to 61 mac terms on the serial mac, then up to three divides on the
// serial divider
// one set in flight at a time; a result is held until its transfer completes
// reset: aresetn synchronous active low clears control state, scratch ram is not cleared
module circumcenter_3d_fixed #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    input  logic signed [15:0] s_point_z,
    input  logic               s_last_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_center_x,
    output logic signed [47:0] m_center_y,
    output logic signed [47:0] m_center_z,
    output logic [1:0]         m_status
);

    // scratch word: holds the largest numerator of the three-point case
    localparam int RW = 5 * COORD_BITS + 8;
    localparam int AW = cc3d_pkg::ADDR_W;
    localparam int OW = cc3d_pkg::OUT_W;

    cc3d_pkg::state_t  state_reg, state_next;
    cc3d_pkg::mode_t   mode_reg, mode_next;
    cc3d_pkg::status_t status_reg, status_next;
    logic [2:0]                 cnt_reg, cnt_next;
    logic                       over_reg, over_next;
    logic [15:0]                hold_y_reg, hold_y_next;
    logic [15:0]                hold_z_reg, hold_z_next;
    logic                       hold_last_reg, hold_last_next;
    logic                       hold_store_reg, hold_store_next;
    logic [AW-1:0]              base_reg, base_next;
    logic [cc3d_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [1:0]                 j_reg, j_next;
    logic [OW-1:0]              cx_reg, cx_next;
    logic [OW-1:0]              cy_reg, cy_next;
    logic [OW-1:0]              cz_reg, cz_next;

    cc3d_pkg::uop_t     uop;
    cc3d_pkg::mac_cmd_t mac_cmd;
    logic               ram_we;
    logic [AW-1:0]      ram_wa;
    logic [RW-1:0]      ram_wd;
    logic [AW-1:0]      ram_ra_a;
    logic [AW-1:0]      ram_ra_b;
    logic [RW-1:0]      rd_a;
    logic [RW-1:0]      rd_b;
    logic [RW-1:0]      mac_x;
    logic [RW-1:0]      mac_y;
    logic               mac_done;
    logic [RW-1:0]      mac_acc;
    logic               div_start;
    logic               div_done;
    logic [OW-1:0]      div_q;
    logic [2:0]         cnt_m1;

    // port value taken as COORD_BITS two's complement, zero filled when wider
    function automatic logic [RW-1:0] sext_coord(input logic [15:0] f);
        logic [COORD_BITS+15:0] ext;
        logic [COORD_BITS-1:0]  c;
        ext = {{COORD_BITS{1'b0}}, f};
        c   = ext[COORD_BITS-1:0];
        return {{(RW - COORD_BITS){c[COORD_BITS-1]}}, c};
    endfunction

    function automatic logic [RW-1:0] opnd_val(input cc3d_pkg::opnd_t o,
                                               input logic [RW-1:0] rd);
        case (o.src)
            cc3d_pkg::SRC_ONE: return RW'(1);
            cc3d_pkg::SRC_TWO: return RW'(2);
            default:           return rd;
        endcase
    endfunction

    assign uop      = cc3d_pkg::prog_at(mode_reg, pc_reg);
    assign cnt_m1   = cnt_reg - 3'd1;
    assign mac_x    = opnd_val(uop.x, rd_a);
    assign mac_y    = opnd_val(uop.y, rd_b);

    assign s_ready    = (state_reg == cc3d_pkg::ST_IDLE);
    assign m_valid    = (state_reg == cc3d_pkg::ST_RESULT);
    assign m_center_x = cx_reg;
    assign m_center_y = cy_reg;
    assign m_center_z = cz_reg;
    assign m_status   = status_reg;

    cc3d_ram #(
        .WIDTH (RW),
        .DEPTH (cc3d_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .wa   (ram_wa),
        .wd   (ram_wd),
        .ra_a (ram_ra_a),
        .ra_b (ram_ra_b),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    cc3d_mac #(
        .W (RW)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .x_in    (mac_x),
        .y_in    (mac_y),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    cc3d_div #(
        .RW        (RW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (rd_a),
        .den     (rd_b),
        .done    (div_done),
        .quot    (div_q)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cc3d_pkg::ST_IDLE;
            cnt_reg   <= '0;
            over_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            over_reg  <= over_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        status_reg     <= status_next;
        hold_y_reg     <= hold_y_next;
        hold_z_reg     <= hold_z_next;
        hold_last_reg  <= hold_last_next;
        hold_store_reg <= hold_store_next;
        base_reg       <= base_next;
        pc_reg         <= pc_next;
        j_reg          <= j_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        status_next     = status_reg;
        cnt_next        = cnt_reg;
        over_next       = over_reg;
        hold_y_next     = hold_y_reg;
        hold_z_next     = hold_z_reg;
        hold_last_next  = hold_last_reg;
        hold_store_next = hold_store_reg;
        base_next       = base_reg;
        pc_next         = pc_reg;
        j_next          = j_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        ram_we          = 1'b0;
        ram_wa          = '0;
        ram_wd          = sext_coord(s_point_x);
        ram_ra_a        = '0;
        ram_ra_b        = '0;
        mac_cmd         = '0;
        div_start       = 1'b0;
        case (state_reg)
            cc3d_pkg::ST_IDLE: begin
                // x coordinate goes straight in, y and z follow from holding regs
                if (s_valid) begin
                    hold_store_next = (cnt_reg < 3'(cc3d_pkg::MAX_POINTS));
                    base_next       = AW'({cnt_reg[1:0], 1'b0}) + AW'(cnt_reg[1:0]);
                    hold_y_next     = s_point_y;
                    hold_z_next     = s_point_z;
                    hold_last_next  = s_last_point;
                    ram_we          = hold_store_next;
                    ram_wa          = base_next;
                    if (hold_store_next) begin
                        cnt_next = cnt_reg + 3'd1;
                    end else begin
                        over_next = 1'b1;
                    end
                    state_next = cc3d_pkg::ST_WR_Y;
                end
            end
            cc3d_pkg::ST_WR_Y: begin
                ram_we     = hold_store_reg;
                ram_wa     = base_reg + AW'(1);
                ram_wd     = sext_coord(hold_y_reg);
                state_next = cc3d_pkg::ST_WR_Z;
            end
            cc3d_pkg::ST_WR_Z: begin
                ram_we = hold_store_reg;
                ram_wa = base_reg + AW'(2);
                ram_wd = sext_coord(hold_z_reg);
                if (!hold_last_reg) begin
                    state_next = cc3d_pkg::ST_IDLE;
                end else begin
                    cnt_next  = '0;
                    over_next = 1'b0;
                    if (over_reg) begin
                        status_next = cc3d_pkg::STAT_TOO_MANY;
                        cx_next     = '0;
                        cy_next     = '0;
                        cz_next     = '0;
                        state_next  = cc3d_pkg::ST_RESULT;
                    end else begin
                        mode_next  = cc3d_pkg::mode_t'(cnt_m1[1:0]);
                        pc_next    = '0;
                        state_next = cc3d_pkg::ST_FETCH;
                    end
                end
            end
            cc3d_pkg::ST_FETCH: begin
                ram_ra_a = uop.x.addr;
                ram_ra_b = uop.y.addr;
                if (uop.stop) begin
                    j_next     = '0;
                    state_next = cc3d_pkg::ST_DIV_FETCH;
                end else begin
                    state_next = cc3d_pkg::ST_MAC_START;
                end
            end
            cc3d_pkg::ST_MAC_START: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clr   = uop.clr;
                mac_cmd.neg   = uop.neg;
                state_next    = cc3d_pkg::ST_MAC_RUN;
            end
            cc3d_pkg::ST_MAC_RUN: begin
                if (mac_done) begin
                    state_next = cc3d_pkg::ST_WB;
                end
            end
            cc3d_pkg::ST_WB: begin
                ram_we     = uop.wr;
                ram_wa     = uop.wa;
                ram_wd     = mac_acc;
                pc_next    = pc_reg + cc3d_pkg::PC_W'(1);
                state_next = cc3d_pkg::ST_FETCH;
            end
            cc3d_pkg::ST_DIV_FETCH: begin
                ram_ra_a   = AW'(cc3d_pkg::A_N) + AW'(j_reg);
                ram_ra_b   = AW'(cc3d_pkg::A_D);
                state_next = cc3d_pkg::ST_DIV_START;
            end
            cc3d_pkg::ST_DIV_START: begin
                // zero denominator: collinear or coplanar set
                if (rd_b == '0) begin
                    status_next = cc3d_pkg::STAT_DEGEN;
                    cx_next     = '0;
                    cy_next     = '0;
                    cz_next     = '0;
                    state_next  = cc3d_pkg::ST_RESULT;
                end else begin
                    div_start  = 1'b1;
                    state_next = cc3d_pkg::ST_DIV_RUN;
                end
            end
            cc3d_pkg::ST_DIV_RUN: begin
                if (div_done) begin
                    case (j_reg)
                        2'd0:    cx_next = div_q;
                        2'd1:    cy_next = div_q;
                        default: cz_next = div_q;
                    endcase
                    if (j_reg == 2'd2) begin
                        status_next = cc3d_pkg::STAT_OK;
                        state_next  = cc3d_pkg::ST_RESULT;
                    end else begin
                        j_next     = j_reg + 2'd1;
                        state_next = cc3d_pkg::ST_DIV_FETCH;
                    end
                end
            end
            cc3d_pkg::ST_RESULT: begin
                if (m_ready) begin
                    state_next = cc3d_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cc3d_pkg::ST_IDLE;
            end
        endcase
    end

    // stored point count never passes the store depth
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(cc3d_pkg::MAX_POINTS))
        else $error("point count out of range");

    // an error result carries a zero center
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != cc3d_pkg::STAT_OK))
            |-> (m_center_x == '0 && m_center_y == '0 && m_center_z == '0))
        else $error("error result with nonzero center");

    // never loading and presenting a result at once
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // a result transfer returns the block to loading
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (s_ready && cnt_reg == '0))
        else $error("not idle after result transfer");

endmodule

// ===== tb/tb_circumcenter_3d_fixed.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the 3d circumcenter block
module tb_circumcenter_3d_fixed;

    // wide enough for every exact product of the solver, no overflow
    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [47:0] cx;
        logic signed [47:0] cy;
        logic signed [47:0] cz;
        cc3d_pkg::status_t  status;
    } center_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_point_x;
    logic signed [15:0] s_point_y;
    logic signed [15:0] s_point_z;
    logic               s_last_point;
    logic               m_valid;
    logic               m_ready;
    logic signed [47:0] m_center_x;
    logic signed [47:0] m_center_y;
    logic signed [47:0] m_center_z;
    logic [1:0]         m_status;

    // point set as the block should hold it
    wide_t     set_pts [4][3];
    int        set_count;
    logic      set_overflow;
    center_t   centers_due [$];
    int        err_count;
    int        points_sent;
    int        hold_cycles;

    circumcenter_3d_fixed u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_point_z    (s_point_z),
        .s_last_point (s_last_point),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_center_x   (m_center_x),
        .m_center_y   (m_center_y),
        .m_center_z   (m_center_z),
        .m_status     (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // generous fixed limit: every item closing a four point set at full stall
    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    // -------- predictor --------

    // round(num * 2^16 / den), ties away from zero, saturate to 48 bits
    function automatic logic signed [47:0] to_fixed(input wide_t num, input wide_t den);
        wide_t n;
        wide_t d;
        wide_t q;
        wide_t r;
        logic  neg;
        n = num <<< 16;
        d = den;
        neg = (n < 0) != (d < 0);
        if (n < 0) n = -n;
        if (d < 0) d = -d;
        q = n / d;
        r = n % d;
        if (2 * r >= d) q = q + 1;
        if (neg) q = -q;
        if (q > (wide_t'(1) <<< 47) - 1) return {1'b0, {47{1'b1}}};
        if (q < -(wide_t'(1) <<< 47)) return {1'b1, {47{1'b0}}};
        return q[47:0];
    endfunction

    function automatic wide_t det3(input wide_t a, input wide_t b, input wide_t c,
                                   input wide_t d, input wide_t e, input wide_t f,
                                   input wide_t g, input wide_t h, input wide_t i);
        return a * (e * i - f * h) - b * (d * i - f * g) + c * (d * h - e * g);
    endfunction

    // center of the currently held set
    function automatic center_t circumcenter();
        center_t res;
        wide_t   u [3];
        wide_t   v [3];
        wide_t   w [3];
        wide_t   nrm [3];
        wide_t   nu [3];
        wide_t   nv [3];
        wide_t   rhs [3];
        wide_t   den;
        wide_t   uu;
        wide_t   vv;
        wide_t   s0;
        wide_t   num [3];
        res.status = cc3d_pkg::STAT_OK;
        if (set_overflow) begin
            res.status = cc3d_pkg::STAT_TOO_MANY;
            res.cx = '0; res.cy = '0; res.cz = '0;
            return res;
        end
        if (set_count == 1) begin
            for (int k = 0; k < 3; k++) begin
                num[k] = set_pts[0][k];
            end
            den = 1;
        end else if (set_count == 2) begin
            for (int k = 0; k < 3; k++) begin
                num[k] = set_pts[0][k] + set_pts[1][k];
            end
            den = 2;
        end else if (set_count == 3) begin
            for (int k = 0; k < 3; k++) begin
                u[k] = set_pts[1][k] - set_pts[0][k];
                v[k] = set_pts[2][k] - set_pts[0][k];
            end
            for (int k = 0; k < 3; k++) begin
                nrm[k] = u[(k+1)%3] * v[(k+2)%3] - u[(k+2)%3] * v[(k+1)%3];
            end
            den = 2 * (nrm[0]*nrm[0] + nrm[1]*nrm[1] + nrm[2]*nrm[2]);
            for (int k = 0; k < 3; k++) begin
                nu[k] = nrm[(k+1)%3] * u[(k+2)%3] - nrm[(k+2)%3] * u[(k+1)%3];
                nv[k] = nrm[(k+1)%3] * v[(k+2)%3] - nrm[(k+2)%3] * v[(k+1)%3];
            end
            uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
            vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
            for (int k = 0; k < 3; k++) begin
                num[k] = set_pts[0][k] * den + vv * nu[k] - uu * nv[k];
            end
        end else begin
            s0 = set_pts[0][0]**2 + set_pts[0][1]**2 + set_pts[0][2]**2;
            for (int k = 0; k < 3; k++) begin
                u[k] = set_pts[1][k] - set_pts[0][k];
                v[k] = set_pts[2][k] - set_pts[0][k];
                w[k] = set_pts[3][k] - set_pts[0][k];
            end
            for (int i = 0; i < 3; i++) begin
                rhs[i] = set_pts[i+1][0]**2 + set_pts[i+1][1]**2 + set_pts[i+1][2]**2 - s0;
            end
            den = 2 * det3(u[0], u[1], u[2], v[0], v[1], v[2], w[0], w[1], w[2]);
            // cramer: replace column j by the right-hand side
            num[0] = det3(rhs[0], u[1], u[2], rhs[1], v[1], v[2], rhs[2], w[1], w[2]);
            num[1] = det3(u[0], rhs[0], u[2], v[0], rhs[1], v[2], w[0], rhs[2], w[2]);
            num[2] = det3(u[0], u[1], rhs[0], v[0], v[1], rhs[1], w[0], w[1], rhs[2]);
        end
        if (den == 0) begin
            res.status = cc3d_pkg::STAT_DEGEN;
            res.cx = '0; res.cy = '0; res.cz = '0;
            return res;
        end
        res.cx = to_fixed(num[0], den);
        res.cy = to_fixed(num[1], den);
        res.cz = to_fixed(num[2], den);
        return res;
    endfunction

    // update the held set on an accepted point, queue a center when it closes
    task automatic take_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z, input logic last);
        if (set_count < cc3d_pkg::MAX_POINTS) begin
            set_pts[set_count][0] = x;
            set_pts[set_count][1] = y;
            set_pts[set_count][2] = z;
            set_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (last) begin
            centers_due.push_back(circumcenter());
            set_count = 0;
            set_overflow = 1'b0;
        end
    endtask

    // -------- stimulus --------

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one point transfer; called and returning at a falling edge
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_point_x    <= x;
        s_point_y    <= y;
        s_point_z    <= z;
        s_last_point <= last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        take_point(x, y, z, last);
        points_sent++;
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] any_coord();
        return 16'($urandom());
    endfunction

    function automatic logic signed [15:0] mid_coord();
        return $signed(16'($urandom_range(0, 20000))) - 16'sd10000;
    endfunction

    // well formed set of n points with random content, last on the final one
    task automatic send_set(input int n, input logic full_range);
        for (int i = 0; i < n; i++) begin
            if (full_range) begin
                send_point(any_coord(), any_coord(), any_coord(), i == n - 1);
            end else begin
                send_point(mid_coord(), mid_coord(), mid_coord(), i == n - 1);
            end
        end
    endtask

    // three collinear points, or four coplanar ones
    task automatic send_flat_set(input int n);
        logic signed [15:0] a [3];
        logic signed [15:0] du [3];
        logic signed [15:0] dv [3];
        for (int k = 0; k < 3; k++) begin
            a[k]  = mid_coord();
            du[k] = $signed(16'($urandom_range(0, 200))) - 16'sd100;
            dv[k] = $signed(16'($urandom_range(0, 200))) - 16'sd100;
        end
        send_point(a[0], a[1], a[2], 1'b0);
        send_point(a[0] + du[0], a[1] + du[1], a[2] + du[2], 1'b0);
        if (n == 3) begin
            send_point(a[0] + 16'sd3 * du[0], a[1] + 16'sd3 * du[1],
                       a[2] + 16'sd3 * du[2], 1'b1);
        end else begin
            send_point(a[0] + dv[0], a[1] + dv[1], a[2] + dv[2], 1'b0);
            send_point(a[0] + du[0] + dv[0], a[1] + du[1] + dv[1],
                       a[2] + du[2] + dv[2], 1'b1);
        end
    endtask

    task automatic test_directed();
        // single points at the coordinate extremes
        send_point(16'sh7fff, 16'sh8000, 16'sh0000, 1'b1);
        send_point(16'sh8000, 16'sh7fff, 16'shffff, 1'b1);
        // midpoint with a half lsb, and of the two extremes
        send_point(16'sd1, 16'sd0, -16'sd3, 1'b0);
        send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_point(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
        // right triangle
        send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_point(16'sd4, 16'sd0, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd6, 16'sd0, 1'b1);
        // right-corner tetrahedron with legs of two
        send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_point(16'sd2, 16'sd0, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd2, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd0, 16'sd2, 1'b1);
        // more than four points
        for (int i = 0; i < 5; i++) begin
            send_point(16'(7 * i), -16'sd3, 16'sd1, i == 4);
        end
        // degenerate: collinear triangle, then coplanar tetrahedron
        send_flat_set(3);
        send_flat_set(4);
    endtask

    task automatic test_random();
        int r;
        while (points_sent < 1400) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                send_set($urandom_range(1, 4), 1'($urandom_range(0, 1)));
            end else if (r < 93) begin
                send_flat_set($urandom_range(3, 4));
            end else begin
                send_set($urandom_range(5, 7), 1'b1);
            end
        end
    endtask

    // receiver holds off long while sets keep coming
    task automatic test_backpressure();
        hold_cycles = 4000;
        for (int i = 0; i < 4; i++) begin
            send_set($urandom_range(1, 4), 1'b1);
        end
    endtask

    // -------- result side --------

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                // bursts of stall, including long ones, and stretches of always ready
                case ($urandom_range(0, 19))
                    0: begin
                        m_ready     <= 1'b0;
                        hold_cycles = $urandom_range(10, 60);
                    end
                    1, 2:    m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    // check each result transfer against the oldest predicted center
    always @(posedge aclk) begin
        center_t want;
        if (aresetn && m_valid && m_ready) begin
            if (centers_due.size() == 0) begin
                $error("unexpected result transfer");
                err_count++;
            end else begin
                want = centers_due.pop_front();
                if (m_center_x !== want.cx) begin
                    $error("center_x expected %0d got %0d", want.cx, m_center_x);
                    err_count++;
                end
                if (m_center_y !== want.cy) begin
                    $error("center_y expected %0d got %0d", want.cy, m_center_y);
                    err_count++;
                end
                if (m_center_z !== want.cz) begin
                    $error("center_z expected %0d got %0d", want.cz, m_center_z);
                    err_count++;
                end
                if (m_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_status);
                    err_count++;
                end
            end
        end
    end

    // -------- sequence --------

    initial begin
        int waited;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_point_x    = '0;
        s_point_y    = '0;
        s_point_z    = '0;
        s_last_point = 1'b0;
        err_count    = 0;
        points_sent  = 0;
        hold_cycles  = 0;
        set_count    = 0;
        set_overflow = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_backpressure();
        test_random();
        s_valid <= 1'b0;

        // drain: wait for every predicted center to be transferred
        waited = 0;
        while (centers_due.size() != 0 && waited < 2_000_000) begin
            @(posedge aclk);
            waited++;
        end
        if (centers_due.size() != 0) begin
            $display("simulation failed");
            $finish;
        end else begin
            repeat (100) @(posedge aclk);
            if (err_count == 0) begin
                $display("simulation ok");
            end else begin
                $display("simulation failed");
            end
            $finish;
        end
    end

endmodule
